[design/sps_pkg.sv]
// ----------------------------------------------------------------------------
// Square patrol sequencer package
// Shared constants: default widths, reset values, register indexes and
// corner codes.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int TICK_BITS_DEF  = 24;

  localparam int SIDE_LEN_RESET      = 512;
  localparam int ARRIVE_RADIUS_RESET = 51;

  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIDE_LEN    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ARRIVE_RAD  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FINAL_X     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FINAL_Y     = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EMERGENCY_X = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EMERGENCY_Y = 3'd7;

  localparam logic [1:0] CORNER_UL = 2'd0;
  localparam logic [1:0] CORNER_UR = 2'd1;
  localparam logic [1:0] CORNER_LR = 2'd2;
  localparam logic [1:0] CORNER_LL = 2'd3;

  // Request flags carried with a tick through the pipeline.
  typedef struct packed {
    logic emergency;
    logic stop;
  } sps_flags_t;

endpackage

[design/sps_tick_if.sv]
// ----------------------------------------------------------------------------
// Tick channel interface
// Valid/ready channel carrying one position tick.
// ----------------------------------------------------------------------------
interface sps_tick_if #(
  parameter int COORD_BITS = sps_pkg::COORD_BITS_DEF,
  parameter int TICK_BITS  = sps_pkg::TICK_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic                         emergency_req;
  logic                         stop_req;
  logic [TICK_BITS-1:0]         mission_ticks;

  modport source (output valid, pos_x, pos_y, emergency_req, stop_req, mission_ticks,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, emergency_req, stop_req, mission_ticks,
                  output ready);
endinterface

[design/sps_result_if.sv]
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one waypoint result per tick.
// ----------------------------------------------------------------------------
interface sps_result_if #(
  parameter int COORD_BITS = sps_pkg::COORD_BITS_DEF,
  parameter int TICK_BITS  = sps_pkg::TICK_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         publish;
  logic signed [COORD_BITS-1:0] target_x;
  logic signed [COORD_BITS-1:0] target_y;
  logic [TICK_BITS-1:0]         ticks_left;
  logic [2*COORD_BITS:0]        dist_sq;
  logic                         in_mission;
  logic [1:0]                   corner;

  modport source (output valid, publish, target_x, target_y, ticks_left, dist_sq,
                  in_mission, corner, input ready);
  modport sink   (input valid, publish, target_x, target_y, ticks_left, dist_sq,
                  in_mission, corner, output ready);
endinterface

[design/square_patrol_waypoint_sequencer.sv]
// ----------------------------------------------------------------------------
// Square patrol waypoint sequencer
// Timed patrol around a configured square with emergency and stop overrides.
//
//   Channel  Dir  Handshake        Contents
//   tick     in   valid/ready      position, request flags, mission length
//   result   out  valid/ready      publish flag, target, ticks, distance, corner
//   cfg      in   write enable     register index and data, no read-back
//
// One tick is taken per cycle while tick ready is high; a result passes
// the input, distance and result registers in turn before it leaves.
// Reset is synchronous and clears the pipeline and the mission state.
// A stalled result holds the pipeline; ticks are still taken until the
// input and distance registers are both full.
// ----------------------------------------------------------------------------
module square_patrol_waypoint_sequencer #(
  parameter int COORD_BITS = sps_pkg::COORD_BITS_DEF,
  parameter int TICK_BITS  = sps_pkg::TICK_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [sps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]              cfg_wdata,
  sps_tick_if.sink                           tick,
  sps_result_if.source                       result
);

  logic signed [COORD_BITS-1:0] x_left, x_right, y_upper, y_lower;
  logic signed [COORD_BITS-1:0] final_x, final_y, emergency_x, emergency_y;
  logic [2*COORD_BITS-3:0]      radius_sq;

  logic                         drain;
  logic                         s1_valid;
  logic signed [COORD_BITS-1:0] s1_pos_x, s1_pos_y;
  sps_pkg::sps_flags_t          s1_flags;
  logic [TICK_BITS-1:0]         s1_ticks;
  logic [2*COORD_BITS:0]        s1_dist [4];

  sps_cfg_regs #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .x_left      (x_left),
    .x_right     (x_right),
    .y_upper     (y_upper),
    .y_lower     (y_lower),
    .final_x     (final_x),
    .final_y     (final_y),
    .emergency_x (emergency_x),
    .emergency_y (emergency_y),
    .radius_sq   (radius_sq)
  );

  sps_dist_stage #(
    .COORD_BITS (COORD_BITS),
    .TICK_BITS  (TICK_BITS)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick),
    .x_left   (x_left),
    .x_right  (x_right),
    .y_upper  (y_upper),
    .y_lower  (y_lower),
    .drain    (drain),
    .s1_valid (s1_valid),
    .s1_pos_x (s1_pos_x),
    .s1_pos_y (s1_pos_y),
    .s1_flags (s1_flags),
    .s1_ticks (s1_ticks),
    .s1_dist  (s1_dist)
  );

  sps_seq_core #(
    .COORD_BITS (COORD_BITS),
    .TICK_BITS  (TICK_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .s1_valid    (s1_valid),
    .s1_pos_x    (s1_pos_x),
    .s1_pos_y    (s1_pos_y),
    .s1_flags    (s1_flags),
    .s1_ticks    (s1_ticks),
    .s1_dist     (s1_dist),
    .x_left      (x_left),
    .x_right     (x_right),
    .y_upper     (y_upper),
    .y_lower     (y_lower),
    .final_x     (final_x),
    .final_y     (final_y),
    .emergency_x (emergency_x),
    .emergency_y (emergency_y),
    .radius_sq   (radius_sq),
    .drain       (drain),
    .result      (result)
  );

endmodule

[design/sps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the writable registers, derives the saturated square edges and
// registers the squared arrive radius.
// ----------------------------------------------------------------------------
module sps_cfg_regs #(
  parameter int COORD_BITS = sps_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [sps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_wdata,
  output logic signed [COORD_BITS-1:0]        x_left,
  output logic signed [COORD_BITS-1:0]        x_right,
  output logic signed [COORD_BITS-1:0]        y_upper,
  output logic signed [COORD_BITS-1:0]        y_lower,
  output logic signed [COORD_BITS-1:0]        final_x,
  output logic signed [COORD_BITS-1:0]        final_y,
  output logic signed [COORD_BITS-1:0]        emergency_x,
  output logic signed [COORD_BITS-1:0]        emergency_y,
  output logic [2*COORD_BITS-3:0]             radius_sq
);

  localparam int CB = COORD_BITS;

  logic signed [CB-1:0] center_x;
  logic signed [CB-1:0] center_y;
  logic [CB-2:0]        side_len;
  logic [CB-2:0]        arrive_radius;

  logic signed [CB:0]   half_w;
  logic signed [CB:0]   x_lo_w, x_hi_w, y_lo_w, y_hi_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      side_len      <= (CB-1)'(sps_pkg::SIDE_LEN_RESET);
      arrive_radius <= (CB-1)'(sps_pkg::ARRIVE_RADIUS_RESET);
      final_x       <= '0;
      final_y       <= '0;
      emergency_x   <= '0;
      emergency_y   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sps_pkg::REG_CENTER_X:    center_x      <= cfg_wdata;
        sps_pkg::REG_CENTER_Y:    center_y      <= cfg_wdata;
        sps_pkg::REG_SIDE_LEN:    side_len      <= cfg_wdata[CB-2:0];
        sps_pkg::REG_ARRIVE_RAD:  arrive_radius <= cfg_wdata[CB-2:0];
        sps_pkg::REG_FINAL_X:     final_x       <= cfg_wdata;
        sps_pkg::REG_FINAL_Y:     final_y       <= cfg_wdata;
        sps_pkg::REG_EMERGENCY_X: emergency_x   <= cfg_wdata;
        sps_pkg::REG_EMERGENCY_Y: emergency_y   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The user must change the radius only while idle, which the block does not enforce; its square is registered.
  always_ff @(posedge clk) begin
    radius_sq <= {{(CB-1){1'b0}}, arrive_radius} * {{(CB-1){1'b0}}, arrive_radius};
  end

  function automatic logic signed [CB-1:0] sat_coord(input logic signed [CB:0] v);
    logic signed [CB-1:0] r;
    if (v[CB] != v[CB-1]) begin
      r = v[CB] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
    end else begin
      r = v[CB-1:0];
    end
    return r;
  endfunction

  assign half_w = {3'b000, side_len[CB-2:1]};
  assign x_lo_w = {center_x[CB-1], center_x} - half_w;
  assign x_hi_w = {center_x[CB-1], center_x} + half_w;
  assign y_lo_w = {center_y[CB-1], center_y} - half_w;
  assign y_hi_w = {center_y[CB-1], center_y} + half_w;

  assign x_left  = sat_coord(x_lo_w);
  assign x_right = sat_coord(x_hi_w);
  assign y_upper = sat_coord(y_hi_w);
  assign y_lower = sat_coord(y_lo_w);

endmodule

[design/sps_dist_stage.sv]
// ----------------------------------------------------------------------------
// Distance stage
// Registers the incoming tick, then squares the offsets to the square's
// edges and registers the four corner distances with the tick.
// ----------------------------------------------------------------------------
module sps_dist_stage #(
  parameter int COORD_BITS = sps_pkg::COORD_BITS_DEF,
  parameter int TICK_BITS  = sps_pkg::TICK_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  sps_tick_if.sink                      tick,
  input  logic signed [COORD_BITS-1:0]  x_left,
  input  logic signed [COORD_BITS-1:0]  x_right,
  input  logic signed [COORD_BITS-1:0]  y_upper,
  input  logic signed [COORD_BITS-1:0]  y_lower,
  input  logic                          drain,
  output logic                          s1_valid,
  output logic signed [COORD_BITS-1:0]  s1_pos_x,
  output logic signed [COORD_BITS-1:0]  s1_pos_y,
  output sps_pkg::sps_flags_t           s1_flags,
  output logic [TICK_BITS-1:0]          s1_ticks,
  output logic [2*COORD_BITS:0]         s1_dist [4]
);

  localparam int CB = COORD_BITS;
  localparam int DW = 2 * CB + 1;

  logic                 s0_valid;
  logic signed [CB-1:0] s0_pos_x, s0_pos_y;
  sps_pkg::sps_flags_t  s0_flags;
  logic [TICK_BITS-1:0] s0_ticks;
  logic                 s1_load;

  logic [CB-1:0]        mag [4];
  logic [2*CB-1:0]      sq  [4];
  logic [DW-1:0]        sum [4];
  logic [DW-1:0]        dist_next [4];

  assign s1_load    = s0_valid && (!s1_valid || drain);
  assign tick.ready = !s0_valid || s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (tick.ready) begin
      s0_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s0_pos_x       <= tick.pos_x;
      s0_pos_y       <= tick.pos_y;
      s0_flags.emergency <= tick.emergency_req;
      s0_flags.stop  <= tick.stop_req;
      s0_ticks       <= tick.mission_ticks;
    end
  end

  function automatic logic [CB-1:0] abs_diff(input logic signed [CB-1:0] a,
                                             input logic signed [CB-1:0] b);
    logic signed [CB:0] d;
    logic [CB:0]        n;
    d = {a[CB-1], a} - {b[CB-1], b};
    n = -d;
    return d[CB] ? n[CB-1:0] : d[CB-1:0];
  endfunction

  // Offsets: left x, right x, upper y, lower y.
  assign mag[0] = abs_diff(x_left,  s0_pos_x);
  assign mag[1] = abs_diff(x_right, s0_pos_x);
  assign mag[2] = abs_diff(y_upper, s0_pos_y);
  assign mag[3] = abs_diff(y_lower, s0_pos_y);

  for (genvar i = 0; i < 4; i++) begin : g_sq
    assign sq[i] = {{CB{1'b0}}, mag[i]} * {{CB{1'b0}}, mag[i]};
  end

  assign sum[sps_pkg::CORNER_UL] = {1'b0, sq[0]} + {1'b0, sq[2]};
  assign sum[sps_pkg::CORNER_UR] = {1'b0, sq[1]} + {1'b0, sq[2]};
  assign sum[sps_pkg::CORNER_LR] = {1'b0, sq[1]} + {1'b0, sq[3]};
  assign sum[sps_pkg::CORNER_LL] = {1'b0, sq[0]} + {1'b0, sq[3]};

  // Distances are capped at the largest 64-bit value on wide coordinates.
  for (genvar i = 0; i < 4; i++) begin : g_sat
    if (DW > 64) begin : g_cap
      assign dist_next[i] = (sum[i][DW-1:64] != '0)
                            ? {{(DW-64){1'b0}}, {64{1'b1}}} : sum[i];
    end else begin : g_nocap
      assign dist_next[i] = sum[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || drain) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pos_x <= s0_pos_x;
      s1_pos_y <= s0_pos_y;
      s1_flags <= s0_flags;
      s1_ticks <= s0_ticks;
      for (int i = 0; i < 4; i++) begin
        s1_dist[i] <= dist_next[i];
      end
    end
  end

endmodule

[design/sps_seq_core.sv]
// ----------------------------------------------------------------------------
// Sequencer core
// Holds the mission state and applies one tick per transfer into the result
// register. The state registers double as the result payload.
// ----------------------------------------------------------------------------
module sps_seq_core #(
  parameter int COORD_BITS = sps_pkg::COORD_BITS_DEF,
  parameter int TICK_BITS  = sps_pkg::TICK_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s1_valid,
  input  logic signed [COORD_BITS-1:0]  s1_pos_x,
  input  logic signed [COORD_BITS-1:0]  s1_pos_y,
  input  sps_pkg::sps_flags_t           s1_flags,
  input  logic [TICK_BITS-1:0]          s1_ticks,
  input  logic [2*COORD_BITS:0]         s1_dist [4],
  input  logic signed [COORD_BITS-1:0]  x_left,
  input  logic signed [COORD_BITS-1:0]  x_right,
  input  logic signed [COORD_BITS-1:0]  y_upper,
  input  logic signed [COORD_BITS-1:0]  y_lower,
  input  logic signed [COORD_BITS-1:0]  final_x,
  input  logic signed [COORD_BITS-1:0]  final_y,
  input  logic signed [COORD_BITS-1:0]  emergency_x,
  input  logic signed [COORD_BITS-1:0]  emergency_y,
  input  logic [2*COORD_BITS-3:0]       radius_sq,
  output logic                          drain,
  sps_result_if.source                  result
);

  localparam int CB = COORD_BITS;
  localparam int DW = 2 * CB + 1;

  logic                 out_valid;
  logic                 publish;
  logic                 active;
  logic                 stop_armed;
  logic [1:0]           cur_corner;
  logic [1:0]           last_corner;
  logic                 last_valid;
  logic [TICK_BITS-1:0] remaining;
  logic signed [CB-1:0] held_x, held_y;
  logic [DW-1:0]        last_dist;

  logic                 publish_next;
  logic                 active_next;
  logic                 stop_armed_next;
  logic [1:0]           cur_corner_next;
  logic [1:0]           last_corner_next;
  logic                 last_valid_next;
  logic [TICK_BITS-1:0] remaining_next;
  logic signed [CB-1:0] held_x_next, held_y_next;
  logic [DW-1:0]        last_dist_next;

  logic [1:0]           near_lo, near_hi, nearest;
  logic [DW-1:0]        cur_dist;
  logic [1:0]           step_corner;

  assign drain = s1_valid && (!out_valid || result.ready);

  // Nearest corner: pairwise then final compare; ties keep the lower index.
  assign near_lo = (s1_dist[sps_pkg::CORNER_UR] < s1_dist[sps_pkg::CORNER_UL])
                   ? sps_pkg::CORNER_UR : sps_pkg::CORNER_UL;
  assign near_hi = (s1_dist[sps_pkg::CORNER_LL] < s1_dist[sps_pkg::CORNER_LR])
                   ? sps_pkg::CORNER_LL : sps_pkg::CORNER_LR;
  assign nearest = (s1_dist[near_hi] < s1_dist[near_lo]) ? near_hi : near_lo;

  assign cur_dist    = s1_dist[cur_corner];
  assign step_corner = (cur_dist < {{(DW-(2*CB-2)){1'b0}}, radius_sq})
                       ? cur_corner + 2'd1 : cur_corner;

  always_comb begin
    publish_next     = 1'b0;
    active_next      = active;
    stop_armed_next  = stop_armed;
    cur_corner_next  = cur_corner;
    last_corner_next = last_corner;
    last_valid_next  = last_valid;
    remaining_next   = remaining;
    held_x_next      = held_x;
    held_y_next      = held_y;
    last_dist_next   = last_dist;
    if (s1_flags.emergency || s1_flags.stop) begin
      // A held request publishes only on the tick that raises it.
      if (stop_armed) begin
        held_x_next     = s1_flags.emergency ? emergency_x : s1_pos_x;
        held_y_next     = s1_flags.emergency ? emergency_y : s1_pos_y;
        publish_next    = 1'b1;
        remaining_next  = '0;
        active_next     = 1'b0;
        stop_armed_next = 1'b0;
      end
    end else begin
      stop_armed_next = 1'b1;
      priority if (!active) begin
        if (s1_ticks != '0) begin
          cur_corner_next = nearest;
          remaining_next  = s1_ticks;
          active_next     = 1'b1;
        end
      end else if (remaining != '0) begin
        remaining_next  = remaining - TICK_BITS'(1);
        last_dist_next  = cur_dist;
        cur_corner_next = step_corner;
        if (!last_valid || step_corner != last_corner) begin
          held_x_next      = (step_corner == sps_pkg::CORNER_UR ||
                              step_corner == sps_pkg::CORNER_LR) ? x_right : x_left;
          held_y_next      = (step_corner == sps_pkg::CORNER_UL ||
                              step_corner == sps_pkg::CORNER_UR) ? y_upper : y_lower;
          publish_next     = 1'b1;
          last_corner_next = step_corner;
          last_valid_next  = 1'b1;
        end
      end else begin
        held_x_next  = final_x;
        held_y_next  = final_y;
        publish_next = 1'b1;
        active_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      publish     <= 1'b0;
      active      <= 1'b0;
      stop_armed  <= 1'b1;
      cur_corner  <= sps_pkg::CORNER_UL;
      last_corner <= sps_pkg::CORNER_UL;
      last_valid  <= 1'b0;
      remaining   <= '0;
      held_x      <= '0;
      held_y      <= '0;
      last_dist   <= '0;
    end else begin
      if (!out_valid || result.ready) begin
        out_valid <= s1_valid;
      end
      if (drain) begin
        publish     <= publish_next;
        active      <= active_next;
        stop_armed  <= stop_armed_next;
        cur_corner  <= cur_corner_next;
        last_corner <= last_corner_next;
        last_valid  <= last_valid_next;
        remaining   <= remaining_next;
        held_x      <= held_x_next;
        held_y      <= held_y_next;
        last_dist   <= last_dist_next;
      end
    end
  end

  assign result.valid      = out_valid;
  assign result.publish    = publish;
  assign result.target_x   = held_x;
  assign result.target_y   = held_y;
  assign result.ticks_left = remaining;
  assign result.dist_sq    = last_dist;
  assign result.in_mission = active;
  assign result.corner     = cur_corner;

endmodule

[design/sps_checker.sv]
// ----------------------------------------------------------------------------
// Sequencer port checker
// Watches the top-level channels for handshake and mission consistency.
// ----------------------------------------------------------------------------
module sps_checker #(
  parameter int COORD_BITS = sps_pkg::COORD_BITS_DEF,
  parameter int TICK_BITS  = sps_pkg::TICK_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         tick_ready,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic signed [COORD_BITS-1:0] result_target_x,
  input logic signed [COORD_BITS-1:0] result_target_y,
  input logic [TICK_BITS-1:0]         result_ticks_left,
  input logic                         result_in_mission
);

  // A reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // With the result register empty, nothing can hold back the input side.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> tick_ready)
    else $error("tick not ready while result register empty");

  // Outside a patrol the tick counter is always cleared.
  a_idle_no_ticks: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_in_mission) |-> (result_ticks_left == '0))
    else $error("ticks left while not in mission");

  // A stalled transfer keeps its target.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      ($stable(result_target_x) && $stable(result_target_y)))
    else $error("result target changed while stalled");

endmodule

bind square_patrol_waypoint_sequencer sps_checker #(
  .COORD_BITS (COORD_BITS),
  .TICK_BITS  (TICK_BITS)
) u_sps_checker (
  .clk               (clk),
  .rst               (rst),
  .tick_ready        (tick.ready),
  .result_valid      (result.valid),
  .result_ready      (result.ready),
  .result_target_x   (result.target_x),
  .result_target_y   (result.target_y),
  .result_ticks_left (result.ticks_left),
  .result_in_mission (result.in_mission)
);

[tb/tb_square_patrol_waypoint_sequencer.sv]
// ----------------------------------------------------------------------------
// Square patrol waypoint sequencer testbench
// Drives position ticks and register writes into the sequencer, predicts
// every waypoint result from its own copy of the patrol state and checks
// each result transfer field by field, in order. Both channels idle and
// stall at random; the register settings change between phases.
// ----------------------------------------------------------------------------
module tb_square_patrol_waypoint_sequencer;

  localparam int CW = sps_pkg::COORD_BITS_DEF;
  localparam int TW = sps_pkg::TICK_BITS_DEF;
  localparam int IW = sps_pkg::CFG_INDEX_BITS;

  typedef struct {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic                 emergency_req;
    logic                 stop_req;
    logic [TW-1:0]        mission_ticks;
  } tick_t;

  typedef struct {
    logic                 publish;
    logic signed [CW-1:0] target_x;
    logic signed [CW-1:0] target_y;
    logic [TW-1:0]        ticks_left;
    logic [2*CW:0]        dist_sq;
    logic                 in_mission;
    logic [1:0]           corner;
  } waypoint_t;

  class patrol_scoreboard;
    logic signed [CW-1:0] ctr_x, ctr_y, fin_x, fin_y, emg_x, emg_y;
    logic [CW-2:0]        edge_len, radius;
    logic                 active, stop_armed, last_valid;
    logic [1:0]           cur_corner, last_corner;
    logic [TW-1:0]        remaining;
    logic signed [CW-1:0] held_x, held_y;
    logic [2*CW:0]        last_dist;
    waypoint_t            waypoints_due[$];
    int                   errors;
    int                   results_seen;

    function new();
      ctr_x = '0; ctr_y = '0; fin_x = '0; fin_y = '0; emg_x = '0; emg_y = '0;
      edge_len = (CW-1)'(sps_pkg::SIDE_LEN_RESET);
      radius = (CW-1)'(sps_pkg::ARRIVE_RADIUS_RESET);
      active = 1'b0; stop_armed = 1'b1; last_valid = 1'b0;
      cur_corner = sps_pkg::CORNER_UL; last_corner = sps_pkg::CORNER_UL;
      remaining = '0; held_x = '0; held_y = '0; last_dist = '0;
      errors = 0; results_seen = 0;
    endfunction

    function void write_reg(logic [IW-1:0] idx, logic [CW-1:0] data);
      case (idx)
        sps_pkg::REG_CENTER_X:    ctr_x = data;
        sps_pkg::REG_CENTER_Y:    ctr_y = data;
        sps_pkg::REG_SIDE_LEN:    edge_len = data[CW-2:0];
        sps_pkg::REG_ARRIVE_RAD:  radius = data[CW-2:0];
        sps_pkg::REG_FINAL_X:     fin_x = data;
        sps_pkg::REG_FINAL_Y:     fin_y = data;
        sps_pkg::REG_EMERGENCY_X: emg_x = data;
        sps_pkg::REG_EMERGENCY_Y: emg_y = data;
        default: ;
      endcase
    endfunction

    function longint sat_coord(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (CW-1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // Corners follow the live registers; the half edge is truncated.
    function void corner_point(logic [1:0] c, output longint cx, output longint cy);
      longint half;
      half = longint'(edge_len) >>> 1;
      cx = (c == sps_pkg::CORNER_UR || c == sps_pkg::CORNER_LR)
           ? longint'(ctr_x) + half : longint'(ctr_x) - half;
      cy = (c == sps_pkg::CORNER_UL || c == sps_pkg::CORNER_UR)
           ? longint'(ctr_y) + half : longint'(ctr_y) - half;
      cx = sat_coord(cx);
      cy = sat_coord(cy);
    endfunction

    function longint sq_dist(logic [1:0] c, longint px, longint py);
      longint cx, cy;
      corner_point(c, cx, cy);
      return (cx - px) * (cx - px) + (cy - py) * (cy - py);
    endfunction

    function int pending();
      return waypoints_due.size();
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void note_tick(tick_t t);
      waypoint_t w;
      longint    px, py, d, bd, r2, hx, hy;
      logic [1:0] best;
      logic      pub;
      int        c;
      px = longint'(t.pos_x);
      py = longint'(t.pos_y);
      pub = 1'b0;
      if (t.emergency_req || t.stop_req) begin
        // Only the first tick of a held request takes effect.
        if (stop_armed) begin
          held_x = t.emergency_req ? emg_x : t.pos_x;
          held_y = t.emergency_req ? emg_y : t.pos_y;
          pub = 1'b1;
          remaining = '0;
          active = 1'b0;
          stop_armed = 1'b0;
        end
      end else begin
        stop_armed = 1'b1;
        if (!active) begin
          if (t.mission_ticks != '0) begin
            best = sps_pkg::CORNER_UL;
            bd = sq_dist(sps_pkg::CORNER_UL, px, py);
            for (c = 1; c < 4; c++) begin
              d = sq_dist(c[1:0], px, py);
              if (d < bd) begin
                bd = d;
                best = c[1:0];
              end
            end
            cur_corner = best;
            remaining = t.mission_ticks;
            active = 1'b1;
          end
        end else if (remaining != '0) begin
          r2 = longint'(radius) * longint'(radius);
          remaining = remaining - TW'(1);
          d = sq_dist(cur_corner, px, py);
          last_dist = d[2*CW:0];
          if (d < r2) cur_corner = cur_corner + 2'd1;
          if (!last_valid || cur_corner != last_corner) begin
            corner_point(cur_corner, hx, hy);
            held_x = hx[CW-1:0];
            held_y = hy[CW-1:0];
            pub = 1'b1;
            last_corner = cur_corner;
            last_valid = 1'b1;
          end
        end else begin
          held_x = fin_x;
          held_y = fin_y;
          pub = 1'b1;
          active = 1'b0;
        end
      end
      w.publish = pub;
      w.target_x = held_x;
      w.target_y = held_y;
      w.ticks_left = remaining;
      w.dist_sq = last_dist;
      w.in_mission = active;
      w.corner = cur_corner;
      waypoints_due.push_back(w);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want)
        flag_error($sformatf("result %0d: %s expected %0h got %0h",
                             results_seen, name, want, got));
    endfunction

    function void check_result(waypoint_t got);
      waypoint_t want;
      results_seen++;
      if (waypoints_due.size() == 0) begin
        flag_error($sformatf("result %0d arrived with no tick outstanding", results_seen));
        return;
      end
      want = waypoints_due.pop_front();
      check_field("publish", want.publish, got.publish);
      check_field("target_x", want.target_x, got.target_x);
      check_field("target_y", want.target_y, got.target_y);
      check_field("ticks_left", want.ticks_left, got.ticks_left);
      check_field("dist_sq", want.dist_sq, got.dist_sq);
      check_field("in_mission", want.in_mission, got.in_mission);
      check_field("corner", want.corner, got.corner);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic          cfg_wr_en;
  logic [IW-1:0] cfg_index;
  logic [CW-1:0] cfg_wdata;

  sps_tick_if   tick_ch ();
  sps_result_if res_ch ();

  square_patrol_waypoint_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .tick      (tick_ch),
    .result    (res_ch)
  );

  always #1 clk = ~clk;

  patrol_scoreboard sb;
  bit src_idle;
  bit sink_idle;
  int sink_hold_cycles;
  int ticks_sent;

  initial begin
    #1600000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin : tick_monitor
    tick_t t;
    if (!rst && tick_ch.valid && tick_ch.ready) begin
      t.pos_x = tick_ch.pos_x;
      t.pos_y = tick_ch.pos_y;
      t.emergency_req = tick_ch.emergency_req;
      t.stop_req = tick_ch.stop_req;
      t.mission_ticks = tick_ch.mission_ticks;
      sb.note_tick(t);
    end
  end

  always @(posedge clk) begin : result_monitor
    waypoint_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.publish = res_ch.publish;
      got.target_x = res_ch.target_x;
      got.target_y = res_ch.target_y;
      got.ticks_left = res_ch.ticks_left;
      got.dist_sq = res_ch.dist_sq;
      got.in_mission = res_ch.in_mission;
      got.corner = res_ch.corner;
      sb.check_result(got);
    end
  end

  // Result side: one assignment to ready per falling edge at most.
  initial begin : result_sink
    res_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    while (1) begin
      if (sink_hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        repeat (sink_hold_cycles) @(negedge clk);
        sink_hold_cycles = 0;
      end else if (sink_idle && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  function automatic tick_t mk_tick(int x, int y, bit emg, bit stp, int len);
    tick_t t;
    t.pos_x = CW'(x);
    t.pos_y = CW'(y);
    t.emergency_req = emg;
    t.stop_req = stp;
    t.mission_ticks = TW'(len);
    return t;
  endfunction

  // A position within the arrive radius of corner c, clamped to the field range.
  function automatic void near_point(logic [1:0] c, output logic signed [CW-1:0] x,
                                     output logic signed [CW-1:0] y);
    longint cx, cy, b;
    sb.corner_point(c, cx, cy);
    b = (longint'(sb.radius) * 7) / 10;
    x = CW'(sb.sat_coord(cx + longint'($urandom_range(0, 2 * b)) - b));
    y = CW'(sb.sat_coord(cy + longint'($urandom_range(0, 2 * b)) - b));
  endfunction

  function automatic tick_t random_tick(int flag_pct);
    tick_t t;
    t.pos_x = CW'($urandom);
    t.pos_y = CW'($urandom);
    t.emergency_req = ($urandom_range(1, 100) <= flag_pct);
    t.stop_req = ($urandom_range(1, 100) <= flag_pct);
    t.mission_ticks = ($urandom_range(0, 1) == 0) ? TW'($urandom) : '0;
    return t;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_tick(input tick_t t);
    int gap;
    gap = (src_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.pos_x <= t.pos_x;
    tick_ch.pos_y <= t.pos_y;
    tick_ch.emergency_req <= t.emergency_req;
    tick_ch.stop_req <= t.stop_req;
    tick_ch.mission_ticks <= t.mission_ticks;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    tick_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(input logic [CW-1:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= IW'(i);
      cfg_wdata <= vals[i];
      sb.write_reg(IW'(i), vals[i]);
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_directed();
    tick_t seq[$];
    // Default square: corners at +/-256, radius squared 2601.
    seq.push_back(mk_tick(0, 0, 0, 0, 0));
    seq.push_back(mk_tick(0, 0, 0, 0, 3));             // equal distances, lowest corner wins
    seq.push_back(mk_tick(-256, 256, 0, 0, 0));
    seq.push_back(mk_tick(0, 0, 0, 0, 0));
    seq.push_back(mk_tick(306, 256, 0, 0, 0));
    seq.push_back(mk_tick(0, 0, 0, 0, 5));             // expiry ignores the length
    seq.push_back(mk_tick(10, 20, 1, 1, 0));           // emergency beats stop
    seq.push_back(mk_tick(10, 20, 1, 0, 0));
    seq.push_back(mk_tick(10, 20, 0, 1, 7));
    seq.push_back(mk_tick(0, 0, 0, 0, 0));
    seq.push_back(mk_tick(123, -456, 0, 1, 0));
    seq.push_back(mk_tick(0, 0, 0, 1, 9));
    seq.push_back(mk_tick(32767, 32767, 0, 0, 1));
    seq.push_back(mk_tick(-32768, -32768, 0, 0, 0));
    seq.push_back(mk_tick(0, 0, 0, 0, 0));
    seq.push_back(mk_tick(-32768, 32767, 0, 0, 24'hFFFFFF));
    seq.push_back(mk_tick(-205, 256, 0, 0, 0));        // exactly on the radius
    seq.push_back(mk_tick(-256, 306, 0, 0, 0));
    seq.push_back(mk_tick(256, 256, 0, 0, 24'h800000));
    seq.push_back(mk_tick(256, -256, 0, 0, 0));
    seq.push_back(mk_tick(-256, -256, 0, 0, 0));
    seq.push_back(mk_tick(0, 0, 1, 0, 0));
    seq.push_back(mk_tick(0, 0, 0, 0, 0));
    seq.push_back(mk_tick(-1, -1, 0, 0, 1));
    foreach (seq[i]) send_tick(seq[i]);
  endtask

  task automatic run_random(input int count);
    tick_t t;
    int    stop_at, kind, n;
    bit    emg, stp;
    stop_at = ticks_sent + count;
    while (ticks_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        // A patrol: a start tick, then ticks that mostly reach the target.
        t = random_tick(0);
        t.mission_ticks = ($urandom_range(0, 19) == 0) ? TW'($urandom)
                                                      : TW'($urandom_range(1, 12));
        if ($urandom_range(0, 1) == 0) near_point(2'($urandom), t.pos_x, t.pos_y);
        send_tick(t);
        n = $urandom_range(1, 14);
        repeat (n) begin
          t = random_tick(0);
          if ($urandom_range(0, 9) != 0) t.mission_ticks = '0;
          if ($urandom_range(1, 100) <= 70) near_point(sb.cur_corner, t.pos_x, t.pos_y);
          if ($urandom_range(0, 19) == 0) t.emergency_req = 1'b1;
          if ($urandom_range(0, 19) == 0) t.stop_req = 1'b1;
          send_tick(t);
        end
      end else if (kind < 80) begin
        // A held override followed by its release.
        emg = $urandom_range(0, 1);
        stp = !emg || $urandom_range(0, 1);
        n = $urandom_range(1, 4);
        repeat (n) begin
          t = random_tick(0);
          t.emergency_req = emg;
          t.stop_req = stp;
          send_tick(t);
        end
        t = random_tick(0);
        send_tick(t);
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_tick(random_tick(25));
      end
    end
  endtask

  initial begin : stimulus
    logic [CW-1:0] regs[8];
    int            waited;
    sb = new();
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    tick_ch.valid = 1'b0;
    tick_ch.pos_x = '0;
    tick_ch.pos_y = '0;
    tick_ch.emergency_req = 1'b0;
    tick_ch.stop_req = 1'b0;
    tick_ch.mission_ticks = '0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    sink_hold_cycles = 0;
    ticks_sent = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();

    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: regs = '{16'h0100, 16'hFE00, 16'd1024, 16'd128,
                    16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF};
        1: regs = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                    16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};
        2: regs = '{16'h8000, 16'h8000, 16'h0000, 16'h0000,
                    16'h1234, 16'hEDCB, 16'h0001, 16'hFFFE};
        3: regs = '{CW'($urandom_range(0, 16383) - 8192), CW'($urandom_range(0, 16383) - 8192),
                    CW'($urandom_range(64, 4096)), CW'($urandom_range(8, 600)),
                    CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom)};
        4: regs = '{CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                    CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom)};
        default: regs = '{16'h0000, 16'h0000, 16'hFFFF, 16'd300,
                          16'hFF00, 16'h0100, 16'h0200, 16'hFD00};
      endcase
      configure(regs);
      // The first phase runs without any idling on either side.
      src_idle = (phase != 0);
      sink_idle = (phase != 0);
      // The sink holds off long enough for the pipeline to back up into the input.
      if (phase == 2) sink_hold_cycles = 400;
      run_random(175);
    end

    tick_ch.valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() != 0)
      sb.flag_error($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
design/sps_pkg.sv
design/sps_tick_if.sv
design/sps_result_if.sv
design/sps_cfg_regs.sv
design/sps_dist_stage.sv
design/sps_seq_core.sv
design/square_patrol_waypoint_sequencer.sv
design/sps_checker.sv
tb/tb_square_patrol_waypoint_sequencer.sv
